FILE: rtl/core/hosc_pkg.sv
// ----------------------------------------------------------------------------
// hosc_pkg: shared types and constants of the RK4 oscillator core
// Register codes, reset values, operation codes and controller/datapath links.
// ----------------------------------------------------------------------------
package hosc_pkg;

  localparam int Q_W        = 32;   // state and product operand width
  localparam int SUM_W      = 35;   // exact weighted RK4 sum
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [Q_W-1:0] Q_MAX      = 32'sh7FFF_FFFF;
  localparam logic signed [Q_W-1:0] Q_MIN      = 32'sh8000_0000;
  localparam logic        [30:0]    ENERGY_MAX = 31'h7FFF_FFFF;

  // register reset values
  localparam logic        [30:0]    OMEGA_SQ_RST = 31'd16777216;
  localparam logic        [30:0]    TSTEP_RST    = 31'd2108287;
  localparam logic signed [Q_W-1:0] INIT_POS_RST = 32'sd0;
  localparam logic signed [Q_W-1:0] INIT_VEL_RST = 32'sd16777216;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OMEGA_SQ = 2'd0,
    CFG_TSTEP    = 2'd1,
    CFG_INIT_POS = 2'd2,
    CFG_INIT_VEL = 2'd3
  } cfg_idx_t;

  // one entry per product through the shared multiplier, in issue order
  typedef enum logic [3:0] {
    OP_W_X    = 4'd0,   // k1v
    OP_H_K1X  = 4'd1,   // midpoint for k2v
    OP_W_MID2 = 4'd2,   // k2v
    OP_H_K1V  = 4'd3,   // k2x
    OP_H_K2X  = 4'd4,   // midpoint for k3v
    OP_W_MID3 = 4'd5,   // k3v
    OP_H_K2V  = 4'd6,   // k3x
    OP_H_K3X  = 4'd7,   // end point for k4v
    OP_W_MID4 = 4'd8,   // k4v
    OP_H_K3V  = 4'd9,   // k4x
    OP_H_DX   = 4'd10,  // new position
    OP_H_DV   = 4'd11,  // new velocity
    OP_W_NX   = 4'd12,  // w * x_new
    OP_VV     = 4'd13,  // v_new squared
    OP_WX_X   = 4'd14   // wx * x_new
  } op_t;

  typedef struct packed {
    logic start;      // request accepted: restart handling, clear clip
    logic mul_en;     // load product register
    logic post_en;    // round, saturate, write destination
    op_t  op;
    logic div_start;  // launch divide by six
    logic div_sel;    // 0: position sum, 1: velocity sum
    logic div_take;   // capture quotient
    logic emit;       // load output register, bump count
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

endpackage

FILE: rtl/core/hosc_if.sv
// ----------------------------------------------------------------------------
// hosc_if: request and result channels of the RK4 oscillator core
// Valid/ready channels; transfer when both are high at a rising edge.
// ----------------------------------------------------------------------------
interface hosc_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface hosc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position;
  logic signed [31:0] velocity;
  logic        [30:0] energy_twice;
  logic        [31:0] step_count;
  logic               saturated;

  modport source (output valid, output position, output velocity, output energy_twice,
                  output step_count, output saturated, input ready);
  modport sink   (input valid, input position, input velocity, input energy_twice,
                  input step_count, input saturated, output ready);
endinterface

FILE: rtl/core/harmonic_oscillator_rk4_step_core.sv
// ----------------------------------------------------------------------------
// harmonic_oscillator_rk4_step_core: one RK4 step of x'' = -w x per request
// Top level: sequencer, datapath and the channel/config connections.
// ----------------------------------------------------------------------------
// Usage
//   in_chan  : one request per step; restart=1 reloads the initial position
//              and velocity and clears the step count before stepping.
//   out_chan : one result per request: position, velocity, energy_twice
//              (v^2 + w x^2), step_count and a saturation flag.
//   cfg_*    : write-only registers, index 0 omega_squared, 1 time_step,
//              2 initial_position, 3 initial_velocity; write only while idle.
// Sequencing
//   Requests are handled one at a time: the next one is taken only after
//   the result of the last has been loaded into the output register. Each
//   step runs 15 products through the single shared 32x32 multiplier (a
//   multiply state and a round-and-combine state for each) and the
//   divide-by-six unit once for each of the two weighted sums.
// Reset
//   Synchronous, active low: registers to their defaults, state to the
//   default initial values, count to zero. No clearing pass.
// Stall
//   The result waits in the output register; a new request is accepted
//   meanwhile, but its result is held back until the previous one is taken.
// ----------------------------------------------------------------------------
module harmonic_oscillator_rk4_step_core #(
  parameter int FRAC_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  hosc_in_if.sink                             in_chan,
  hosc_out_if.source                          out_chan,
  input  logic                                cfg_we,
  input  logic [hosc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hosc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import hosc_pkg::*;

  dp_cmd_t  cmd;   // sequencer -> datapath
  dp_stat_t stat;  // datapath  -> sequencer

  // sequencer: owns the handshakes and the output valid flag
  hosc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath: registers, multiplier, divider, result register
  hosc_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_restart       (in_chan.restart),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_position     (out_chan.position),
    .out_velocity     (out_chan.velocity),
    .out_energy_twice (out_chan.energy_twice),
    .out_step_count   (out_chan.step_count),
    .out_saturated    (out_chan.saturated)
  );

  // a taken request keeps the block busy for at least the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("request accepted on consecutive cycles");

  // the output register is never loaded over a result still waiting
  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_chan.valid || out_chan.ready))
    else $error("pending result overwritten");

  // every product is followed by its rounding step
  a_mul_then_post: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_en |=> cmd.post_en)
    else $error("product not post-processed");

  // the divider only finishes while a step is in flight
  a_div_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> !in_chan.ready)
    else $error("divider done while idle");

endmodule

FILE: rtl/core/hosc_div6.sv
// ----------------------------------------------------------------------------
// hosc_div6: divide by six, rounded half up
// Halves the magnitude, then divides by three one hex digit per cycle.
// ----------------------------------------------------------------------------
module hosc_div6 (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [hosc_pkg::SUM_W-1:0] num,
  output logic                             done,
  output logic signed [hosc_pkg::Q_W-1:0]  quot
);
  import hosc_pkg::*;

  localparam int DVD_W  = 36;
  localparam int DIGITS = DVD_W / 4;
  localparam int CNT_W  = $clog2(DIGITS);

  logic                    prep_r, run_r, done_r, neg_r;
  logic [CNT_W-1:0]        cnt_r;
  logic signed [SUM_W-1:0] num_r;
  logic [DVD_W-1:0]        dvd_r, quo_r;
  logic [1:0]              rem_r;

  logic signed [SUM_W-1:0] n_val, mag;
  logic                    n_neg;
  logic [5:0]              val;
  logic [11:0]             qprod;
  logic [3:0]              qd;
  logic [5:0]              rem_full;
  logic [Q_W:0]            qmag, qsgn;

  always_comb begin
    n_val = num_r + SUM_W'(3);
    n_neg = n_val[SUM_W-1];
    mag   = n_neg ? (SUM_W'(5) - n_val) : n_val;
    // digit of the divide by three; x*43>>7 is exact for x < 48
    val      = {rem_r, dvd_r[DVD_W-1 -: 4]};
    qprod    = 12'(val) * 12'd43;
    qd       = qprod[10:7];
    rem_full = val - 6'(qd) * 6'd3;
    qmag     = quo_r[Q_W:0];
    qsgn     = neg_r ? ((Q_W+1)'(0) - qmag) : qmag;
  end

  assign done = done_r;
  assign quot = qsgn[Q_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_r <= 1'b0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        prep_r <= 1'b1;
      end
      if (prep_r) begin
        prep_r <= 1'b0;
        run_r  <= 1'b1;
        cnt_r  <= CNT_W'(DIGITS - 1);
      end
      if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
    end
    if (prep_r) begin
      neg_r <= n_neg;
      dvd_r <= {2'b00, mag[SUM_W-1:1]};
      quo_r <= '0;
      rem_r <= 2'd0;
    end
    if (run_r) begin
      dvd_r <= {dvd_r[DVD_W-5:0], 4'd0};
      quo_r <= {quo_r[DVD_W-5:0], qd};
      rem_r <= rem_full[1:0];
    end
  end

endmodule

FILE: rtl/core/hosc_dp.sv
// ----------------------------------------------------------------------------
// hosc_dp: datapath of the RK4 oscillator core
// Config registers, state, shared multiplier, rounding/saturation, RK terms,
// divide-by-six unit, energy and the output register.
// ----------------------------------------------------------------------------
module hosc_dp #(
  parameter int FRAC_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  hosc_pkg::dp_cmd_t                    cmd,
  output hosc_pkg::dp_stat_t                   stat,
  input  logic                                 in_restart,
  input  logic                                 cfg_we,
  input  logic        [hosc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [hosc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic signed [hosc_pkg::Q_W-1:0]      out_position,
  output logic signed [hosc_pkg::Q_W-1:0]      out_velocity,
  output logic        [30:0]                   out_energy_twice,
  output logic        [hosc_pkg::Q_W-1:0]      out_step_count,
  output logic                                 out_saturated
);
  import hosc_pkg::*;

  localparam int PROD_W = 2 * Q_W;
  localparam int RND_W  = PROD_W + 1 - FRAC_BITS;
  localparam logic signed [PROD_W:0]  RND_ADD_F = (PROD_W+1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [PROD_W:0]  RND_ADD_H = (PROD_W+1)'(1) << FRAC_BITS;
  localparam logic signed [RND_W-1:0] R_MAX = RND_W'(Q_MAX);
  localparam logic signed [RND_W-1:0] R_MIN = RND_W'(Q_MIN);
  localparam logic signed [RND_W:0]   E_MAX = (RND_W+1)'(Q_MAX);
  localparam logic signed [Q_W:0]     S_MAX = (Q_W+1)'(Q_MAX);
  localparam logic signed [Q_W:0]     S_MIN = (Q_W+1)'(Q_MIN);

  // configuration
  logic        [30:0]    omega_sq_r, tstep_r;
  logic signed [Q_W-1:0] init_pos_r, init_vel_r;
  // state
  logic signed [Q_W-1:0] pos_r, vel_r;
  logic        [Q_W-1:0] count_r;
  // step working set
  logic signed [Q_W-1:0] k1v_r, k2x_r, k2v_r, k3x_r, k3v_r, k4x_r, k4v_r, mid_r;
  logic signed [Q_W-1:0] dx_r, dv_r, wx_r;
  logic                  wx_ovf_r, clip_r;
  logic signed [RND_W-1:0]  esq_r;
  logic        [30:0]    energy_r;
  logic signed [PROD_W-1:0] prod_r;
  // output register
  logic signed [Q_W-1:0] out_pos_r, out_vel_r;
  logic        [30:0]    out_energy_r;
  logic        [Q_W-1:0] out_count_r;
  logic                  out_sat_r;

  logic signed [Q_W-1:0]    w32, h32, opa, opb, base, rs, comb_sat;
  logic signed [PROD_W:0]   prod_ext, sum_f, sum_h, shf_f, shf_h;
  logic signed [RND_W-1:0]  rnd;
  logic                     half, rc, cc, neg_op, r_ovf, eclip;
  logic signed [Q_W:0]      base_ext, rs_ext, comb33;
  logic signed [RND_W:0]    esum;
  logic signed [SUM_W-1:0]  sx, sv;
  logic signed [Q_W-1:0]    quot;
  logic                     div_done;
  logic        [Q_W-1:0]    count_nxt;

  function automatic logic signed [SUM_W-1:0] ext_sum(input logic signed [Q_W-1:0] a);
    return SUM_W'(a);
  endfunction

  assign w32 = {1'b0, omega_sq_r};
  assign h32 = {1'b0, tstep_r};

  // multiplier operands
  always_comb begin
    opa = w32;
    opb = pos_r;
    unique case (cmd.op)
      OP_W_X:                         begin opa = w32;   opb = pos_r; end
      OP_H_K1X:                       begin opa = h32;   opb = vel_r; end
      OP_W_MID2, OP_W_MID3, OP_W_MID4: begin opa = w32;  opb = mid_r; end
      OP_H_K1V:                       begin opa = h32;   opb = k1v_r; end
      OP_H_K2X:                       begin opa = h32;   opb = k2x_r; end
      OP_H_K2V:                       begin opa = h32;   opb = k2v_r; end
      OP_H_K3X:                       begin opa = h32;   opb = k3x_r; end
      OP_H_K3V:                       begin opa = h32;   opb = k3v_r; end
      OP_H_DX:                        begin opa = h32;   opb = dx_r;  end
      OP_H_DV:                        begin opa = h32;   opb = dv_r;  end
      OP_W_NX:                        begin opa = w32;   opb = pos_r; end
      OP_VV:                          begin opa = vel_r; opb = vel_r; end
      OP_WX_X:                        begin opa = wx_r;  opb = pos_r; end
      default:                        begin opa = w32;   opb = pos_r; end
    endcase
  end

  // rounding (half up), saturation, and the add/negate that follows
  always_comb begin
    half = (cmd.op == OP_H_K1X) || (cmd.op == OP_H_K1V) ||
           (cmd.op == OP_H_K2X) || (cmd.op == OP_H_K2V);
    prod_ext = {prod_r[PROD_W-1], prod_r};
    sum_f    = prod_ext + RND_ADD_F;
    sum_h    = prod_ext + RND_ADD_H;
    shf_f    = sum_f >>> FRAC_BITS;
    shf_h    = sum_h >>> (FRAC_BITS + 1);
    rnd      = half ? shf_h[RND_W-1:0] : shf_f[RND_W-1:0];

    r_ovf = (rnd > R_MAX) || (rnd < R_MIN);
    rc    = r_ovf;
    if (rnd > R_MAX) begin
      rs = Q_MAX;
    end else if (rnd < R_MIN) begin
      rs = Q_MIN;
    end else begin
      rs = rnd[Q_W-1:0];
    end

    neg_op = (cmd.op == OP_W_X) || (cmd.op == OP_W_MID2) ||
             (cmd.op == OP_W_MID3) || (cmd.op == OP_W_MID4);
    base = ((cmd.op == OP_H_K1X) || (cmd.op == OP_H_K2X) ||
            (cmd.op == OP_H_K3X) || (cmd.op == OP_H_DX)) ? pos_r : vel_r;
    base_ext = {base[Q_W-1], base};
    rs_ext   = {rs[Q_W-1], rs};
    comb33   = neg_op ? -rs_ext : (base_ext + rs_ext);
    cc       = (comb33 > S_MAX) || (comb33 < S_MIN);
    if (comb33 > S_MAX) begin
      comb_sat = Q_MAX;
    end else if (comb33 < S_MIN) begin
      comb_sat = Q_MIN;
    end else begin
      comb_sat = comb33[Q_W-1:0];
    end

    // energy terms are non-negative; overflow of wx forces the limit
    esum  = {esq_r[RND_W-1], esq_r} + {rnd[RND_W-1], rnd};
    eclip = wx_ovf_r || (esum > E_MAX);
  end

  // weighted sums k1 + 2 k2 + 2 k3 + k4, exact
  always_comb begin
    sx = ext_sum(vel_r) + (ext_sum(k2x_r) <<< 1) + (ext_sum(k3x_r) <<< 1) + ext_sum(k4x_r);
    sv = ext_sum(k1v_r) + (ext_sum(k2v_r) <<< 1) + (ext_sum(k3v_r) <<< 1) + ext_sum(k4v_r);
  end

  hosc_div6 u_div6 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (cmd.div_sel ? sv : sx),
    .done  (div_done),
    .quot  (quot)
  );

  assign stat.div_done = div_done;
  assign count_nxt     = count_r + 1'b1;

  // configuration and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      omega_sq_r <= OMEGA_SQ_RST;
      tstep_r    <= TSTEP_RST;
      init_pos_r <= INIT_POS_RST;
      init_vel_r <= INIT_VEL_RST;
      pos_r      <= INIT_POS_RST;
      vel_r      <= INIT_VEL_RST;
      count_r    <= '0;
      clip_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_OMEGA_SQ: omega_sq_r <= cfg_wdata[30:0];
          CFG_TSTEP:    tstep_r    <= cfg_wdata[30:0];
          CFG_INIT_POS: init_pos_r <= cfg_wdata;
          CFG_INIT_VEL: init_vel_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.start) begin
        clip_r <= 1'b0;
        if (in_restart) begin
          pos_r   <= init_pos_r;
          vel_r   <= init_vel_r;
          count_r <= '0;
        end
      end
      if (cmd.post_en) begin
        unique case (cmd.op)
          OP_H_DX: begin pos_r <= comb_sat; clip_r <= clip_r | rc | cc; end
          OP_H_DV: begin vel_r <= comb_sat; clip_r <= clip_r | rc | cc; end
          OP_W_NX, OP_VV: ;
          OP_WX_X: clip_r <= clip_r | eclip;
          default: clip_r <= clip_r | rc | cc;
        endcase
      end
      if (cmd.emit) begin
        count_r <= count_nxt;
      end
    end
  end

  // working registers (payload, no reset)
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= opa * opb;
    end
    if (cmd.post_en) begin
      unique case (cmd.op)
        OP_W_X:    k1v_r <= comb_sat;
        OP_H_K1X:  mid_r <= comb_sat;
        OP_W_MID2: k2v_r <= comb_sat;
        OP_H_K1V:  k2x_r <= comb_sat;
        OP_H_K2X:  mid_r <= comb_sat;
        OP_W_MID3: k3v_r <= comb_sat;
        OP_H_K2V:  k3x_r <= comb_sat;
        OP_H_K3X:  mid_r <= comb_sat;
        OP_W_MID4: k4v_r <= comb_sat;
        OP_H_K3V:  k4x_r <= comb_sat;
        OP_W_NX: begin
          wx_r     <= rnd[Q_W-1:0];
          wx_ovf_r <= r_ovf;
        end
        OP_VV:     esq_r <= rnd;
        OP_WX_X:   energy_r <= eclip ? ENERGY_MAX : esum[30:0];
        default: ;
      endcase
    end
    if (cmd.div_take) begin
      if (cmd.div_sel) begin
        dv_r <= quot;
      end else begin
        dx_r <= quot;
      end
    end
    if (cmd.emit) begin
      out_pos_r    <= pos_r;
      out_vel_r    <= vel_r;
      out_energy_r <= energy_r;
      out_count_r  <= count_nxt;
      out_sat_r    <= clip_r;
    end
  end

  assign out_position     = out_pos_r;
  assign out_velocity     = out_vel_r;
  assign out_energy_twice = out_energy_r;
  assign out_step_count   = out_count_r;
  assign out_saturated    = out_sat_r;

endmodule

FILE: rtl/core/hosc_ctrl.sv
// ----------------------------------------------------------------------------
// hosc_ctrl: sequencer of the RK4 oscillator core
// Walks the product list through the shared multiplier, runs both divides
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module hosc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output hosc_pkg::dp_cmd_t  cmd,
  input  hosc_pkg::dp_stat_t stat
);
  import hosc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_MUL      = 6'b000010,
    S_POST     = 6'b000100,
    S_DIV_GO   = 6'b001000,
    S_DIV_WAIT = 6'b010000,
    S_EMIT     = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   div_sel_r, div_sel_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  function automatic op_t next_op(input op_t op);
    op_t nxt;
    unique case (op)
      OP_W_X:    nxt = OP_H_K1X;
      OP_H_K1X:  nxt = OP_W_MID2;
      OP_W_MID2: nxt = OP_H_K1V;
      OP_H_K1V:  nxt = OP_H_K2X;
      OP_H_K2X:  nxt = OP_W_MID3;
      OP_W_MID3: nxt = OP_H_K2V;
      OP_H_K2V:  nxt = OP_H_K3X;
      OP_H_K3X:  nxt = OP_W_MID4;
      OP_W_MID4: nxt = OP_H_K3V;
      OP_H_DX:   nxt = OP_H_DV;
      OP_H_DV:   nxt = OP_W_NX;
      OP_W_NX:   nxt = OP_VV;
      OP_VV:     nxt = OP_WX_X;
      default:   nxt = OP_W_X;
    endcase
    return nxt;
  endfunction

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    div_sel_nxt = div_sel_r;
    cmd         = '0;
    cmd.op      = op_r;
    cmd.div_sel = div_sel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          op_nxt    = OP_W_X;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_POST;
      end
      S_POST: begin
        cmd.post_en = 1'b1;
        priority if (op_r == OP_H_K3V) begin
          div_sel_nxt = 1'b0;
          state_nxt   = S_DIV_GO;
        end else if (op_r == OP_WX_X) begin
          state_nxt = S_EMIT;
        end else begin
          op_nxt    = next_op(op_r);
          state_nxt = S_MUL;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (stat.div_done) begin
          cmd.div_take = 1'b1;
          if (div_sel_r) begin
            op_nxt    = OP_H_DX;
            state_nxt = S_MUL;
          end else begin
            div_sel_nxt = 1'b1;
            state_nxt   = S_DIV_GO;
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.emit | (out_valid_r & ~out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_W_X;
      div_sel_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      div_sel_r   <= div_sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: tb/tb_harmonic_oscillator_rk4_step_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_harmonic_oscillator_rk4_step_core: self-checking bench for the RK4 core
// Sends step requests under several register settings, predicts each result
// with a cycle-free RK4 model in fixed point and compares every field.
// ----------------------------------------------------------------------------
module tb_harmonic_oscillator_rk4_step_core;
  import hosc_pkg::*;

  localparam int FRAC            = 24;    // fraction bits, matches the core default
  localparam int RESET_CYCLES    = 9;
  localparam int RANDOM_REQUESTS = 1600;
  localparam int SETTLE_CYCLES   = 60;    // longer than one step
  // longest quiet spell of a correct run: receiver hold + one step
  // + sender gap + register writes; several times over
  localparam int STALL_LIMIT     = 1000;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic        [30:0] energy_twice;
    logic        [31:0] step_count;
    logic               saturated;
  } osc_result_t;

  // one directed request; reconfig writes all four registers first
  typedef struct packed {
    logic        reconfig;
    logic [31:0] w_raw;
    logic [31:0] h_raw;
    logic [31:0] p0_raw;
    logic [31:0] v0_raw;
    logic        restart;
    logic        typed;     // want holds the result read off by hand
    osc_result_t want;
  } step_row_t;

  localparam osc_result_t NO_RESULT = '0;
  localparam logic [31:0] ONE_Q     = 32'h0100_0000;

  // dt = 0 freezes the state, so only the energy needs working out.
  // omega_squared = 0 with dt = 1.0 moves x by v per step.
  localparam step_row_t STEP_TABLE [0:20] = '{
    // reset state and default registers
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, NO_RESULT},
    // dt = 0: state held, energy = v^2
    '{1'b1, ONE_Q, 32'h0, 32'h0, ONE_Q, 1'b1, 1'b1,
      '{32'sh0, ONE_Q, 31'h0100_0000, 32'd1, 1'b0}},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1,
      '{32'sh0, ONE_Q, 31'h0100_0000, 32'd2, 1'b0}},
    // largest omega, most negative position: w*x clips, energy pinned
    '{1'b1, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1,
      '{32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'd1, 1'b1}},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1,
      '{32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'd2, 1'b1}},
    // bit 31 of the write data is dropped for the 31-bit registers
    '{1'b1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b1, 1'b1,
      '{32'sh7FFF_FFFF, 32'sh0, 31'h0, 32'd1, 1'b0}},
    // most negative velocity: v^2 overflows the energy
    '{1'b1, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 1'b1, 1'b1,
      '{32'sh0, 32'sh8000_0000, 31'h7FFF_FFFF, 32'd1, 1'b1}},
    // free motion at unit speed
    '{1'b1, 32'h0, ONE_Q, 32'h0, ONE_Q, 1'b1, 1'b1,
      '{32'sh0100_0000, ONE_Q, 31'h0100_0000, 32'd1, 1'b0}},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1,
      '{32'sh0200_0000, ONE_Q, 31'h0100_0000, 32'd2, 1'b0}},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1,
      '{32'sh0300_0000, ONE_Q, 31'h0100_0000, 32'd3, 1'b0}},
    // largest omega and dt
    '{1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, ONE_Q, 32'h0, 1'b1, 1'b0, NO_RESULT},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, NO_RESULT},
    '{1'b1, 32'hFFFF_FFFF, 32'h0040_0000, 32'hFF00_0000, 32'h8000_0000, 1'b1, 1'b0,
      NO_RESULT},
    // back to the defaults
    '{1'b1, ONE_Q, 32'h0020_2B7F, 32'h0, ONE_Q, 1'b1, 1'b0, NO_RESULT},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, NO_RESULT},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, NO_RESULT}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hosc_in_if  in_ch ();
  hosc_out_if out_ch ();

  harmonic_oscillator_rk4_step_core #(
    .FRAC_BITS (FRAC)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_ch),
    .out_chan  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Oscillator model: register copies, state, and the RK4 step itself
  // ---------------------------------------------------------------------------
  logic        [30:0] omega_sq_q;
  logic        [30:0] tstep_q;
  logic signed [31:0] init_pos_q;
  logic signed [31:0] init_vel_q;
  longint             osc_pos;
  longint             osc_vel;
  logic        [31:0] osc_count;
  bit                 clip_seen;

  osc_result_t pending_results [$];   // results owed, oldest first
  int          mismatches;
  int          idle_cycles;

  function automatic void reset_model();
    omega_sq_q = OMEGA_SQ_RST;
    tstep_q    = TSTEP_RST;
    init_pos_q = INIT_POS_RST;
    init_vel_q = INIT_VEL_RST;
    osc_pos    = INIT_POS_RST;
    osc_vel    = INIT_VEL_RST;
    osc_count  = '0;
  endfunction

  // floor(p / 2^s + 1/2)
  function automatic longint rnd_shift(longint p, int s);
    return (p + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_q(longint a);
    if (a > longint'(Q_MAX)) begin
      clip_seen = 1'b1;
      return longint'(Q_MAX);
    end
    if (a < longint'(Q_MIN)) begin
      clip_seen = 1'b1;
      return longint'(Q_MIN);
    end
    return a;
  endfunction

  function automatic longint fx_mul(longint a, longint b, int s);
    return clamp_q(rnd_shift(a * b, s));
  endfunction

  // (n + 3) / 6 rounded towards minus infinity, i.e. n / 6 rounded half up
  function automatic longint div_by_six(longint n);
    n = n + 3;
    if (n >= 0)
      return n / 6;
    return -((-n + 5) / 6);
  endfunction

  function automatic osc_result_t rk4_advance(bit restart_bit);
    longint      w, h, x, v;
    longint      k1x, k1v, k2x, k2v, k3x, k3v, k4x, k4v;
    longint      nx, nv, wx, e;
    osc_result_t r;
    clip_seen = 1'b0;
    w = longint'(omega_sq_q);
    h = longint'(tstep_q);
    if (restart_bit) begin
      osc_pos   = init_pos_q;
      osc_vel   = init_vel_q;
      osc_count = '0;
    end
    x = osc_pos;
    v = osc_vel;

    // half steps use dt/2, folded into the shift
    k1x = v;
    k1v = clamp_q(-fx_mul(w, x, FRAC));
    k2x = clamp_q(v + fx_mul(h, k1v, FRAC + 1));
    k2v = clamp_q(-fx_mul(w, clamp_q(x + fx_mul(h, k1x, FRAC + 1)), FRAC));
    k3x = clamp_q(v + fx_mul(h, k2v, FRAC + 1));
    k3v = clamp_q(-fx_mul(w, clamp_q(x + fx_mul(h, k2x, FRAC + 1)), FRAC));
    k4x = clamp_q(v + fx_mul(h, k3v, FRAC));
    k4v = clamp_q(-fx_mul(w, clamp_q(x + fx_mul(h, k3x, FRAC)), FRAC));

    // weighted sums are exact; only the divide rounds
    nx = clamp_q(x + fx_mul(h, div_by_six(k1x + 2 * k2x + 2 * k3x + k4x), FRAC));
    nv = clamp_q(v + fx_mul(h, div_by_six(k1v + 2 * k2v + 2 * k3v + k4v), FRAC));
    osc_pos   = nx;
    osc_vel   = nv;
    osc_count = osc_count + 32'd1;

    wx = rnd_shift(w * nx, FRAC);
    if (wx > longint'(Q_MAX) || wx < longint'(Q_MIN)) begin
      e         = longint'(ENERGY_MAX);
      clip_seen = 1'b1;
    end else begin
      e = rnd_shift(nv * nv, FRAC) + rnd_shift(wx * nx, FRAC);
      if (e > longint'(Q_MAX)) begin
        e         = longint'(ENERGY_MAX);
        clip_seen = 1'b1;
      end
    end

    r.position     = nx[31:0];
    r.velocity     = nv[31:0];
    r.energy_twice = e[30:0];
    r.step_count   = osc_count;
    r.saturated    = clip_seen;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_OMEGA_SQ: omega_sq_q = data[30:0];
      CFG_TSTEP:    tstep_q    = data[30:0];
      CFG_INIT_POS: init_pos_q = data;
      CFG_INIT_VEL: init_vel_q = data;
    endcase
  endtask

  // only called with nothing in flight
  task automatic program_config(input logic [31:0] w_raw, input logic [31:0] h_raw,
                                input logic [31:0] p0_raw, input logic [31:0] v0_raw);
    write_reg(CFG_OMEGA_SQ, w_raw);
    write_reg(CFG_TSTEP, h_raw);
    write_reg(CFG_INIT_POS, p0_raw);
    write_reg(CFG_INIT_VEL, v0_raw);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // holds valid low until every owed result has been taken
  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic send_request(input bit restart_bit, input int gap, input bit typed,
                              input osc_result_t want);
    osc_result_t predicted;
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart_bit;
    @(posedge clk);
    while (!in_ch.ready)
      @(posedge clk);
    // the model is stepped even for hand-typed rows to keep its state in line
    predicted = rk4_advance(restart_bit);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // mostly physically sensible values, now and then anything at all
  task automatic pick_config(output logic [31:0] w_raw, output logic [31:0] h_raw,
                             output logic [31:0] p0_raw, output logic [31:0] v0_raw);
    case ($urandom_range(0, 3))
      0:       w_raw = $urandom_range(0, 32'h1000_0000);
      1:       w_raw = $urandom();
      2:       w_raw = $urandom_range(32'h0010_0000, 32'h0400_0000);
      default: w_raw = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h0;
    endcase
    case ($urandom_range(0, 5))
      0:       h_raw = $urandom();
      1:       h_raw = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h0;
      default: h_raw = $urandom_range(0, 32'h0040_0000);
    endcase
    p0_raw = ($urandom_range(0, 3) == 0) ? $urandom()
                                         : $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
    v0_raw = ($urandom_range(0, 3) == 0) ? $urandom()
                                         : $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
  endtask

  initial begin : stimulus
    step_row_t   row;
    logic [31:0] w_raw, h_raw, p0_raw, v0_raw;
    int          sent;
    int          burst_left;
    int          gap;
    int          phase_len;
    bit          calm;
    bit          restart_bit;

    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.restart = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_OMEGA_SQ;
    cfg_wdata     = '0;
    mismatches    = 0;
    reset_model();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part: back to back, draining before each register change
    foreach (STEP_TABLE[i]) begin
      row = STEP_TABLE[i];
      if (row.reconfig) begin
        wait_for_results();
        program_config(row.w_raw, row.h_raw, row.p0_raw, row.v0_raw);
      end
      send_request(row.restart, 0, row.typed, row.want);
    end

    // random part: phases of steady stepping, each under fresh registers
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      wait_for_results();
      pick_config(w_raw, h_raw, p0_raw, v0_raw);
      program_config(w_raw, h_raw, p0_raw, v0_raw);
      calm       = ($urandom_range(0, 4) == 0);   // a phase with no sender gaps
      phase_len  = $urandom_range(80, 220);
      burst_left = 0;
      for (int n = 0; n < phase_len && sent < RANDOM_REQUESTS; n++) begin
        gap = 0;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          if (!calm && $urandom_range(0, 3) != 0)
            gap = $urandom_range(1, 30);
        end
        burst_left--;
        // a phase usually opens from the new initial state
        restart_bit = (n == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 15) == 0);
        send_request(restart_bit, gap, 1'b0, NO_RESULT);
        sent++;
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);   // catch any stray result
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: open windows and holds of random length
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int open_len;
    int hold_len;
    out_ch.ready = 1'b0;
    forever begin
      open_len = ($urandom_range(0, 7) == 0) ? 800 : $urandom_range(1, 150);
      hold_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
      repeat (open_len) @(negedge clk) out_ch.ready <= 1'b1;
      repeat (hold_len) @(negedge clk) out_ch.ready <= 1'b0;
    end
  end

  task automatic compare_result(input osc_result_t want, input osc_result_t got);
    if (got.position !== want.position) begin
      $error("position: expected %h, got %h", want.position, got.position);
      mismatches++;
    end
    if (got.velocity !== want.velocity) begin
      $error("velocity: expected %h, got %h", want.velocity, got.velocity);
      mismatches++;
    end
    if (got.energy_twice !== want.energy_twice) begin
      $error("energy_twice: expected %h, got %h", want.energy_twice, got.energy_twice);
      mismatches++;
    end
    if (got.step_count !== want.step_count) begin
      $error("step_count: expected %0d, got %0d", want.step_count, got.step_count);
      mismatches++;
    end
    if (got.saturated !== want.saturated) begin
      $error("saturated: expected %b, got %b", want.saturated, got.saturated);
      mismatches++;
    end
  endtask

  // checks each result taken and watches for a hung handshake
  always @(posedge clk) begin : result_monitor
    osc_result_t got;
    bit          out_fire;
    bit          in_fire;
    out_fire = (out_ch.valid === 1'b1) && (out_ch.ready === 1'b1);
    in_fire  = (in_ch.valid === 1'b1) && (in_ch.ready === 1'b1);
    if (out_fire) begin
      got = '{out_ch.position, out_ch.velocity, out_ch.energy_twice,
              out_ch.step_count, out_ch.saturated};
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: position %h", got.position);
        mismatches++;
      end else begin
        compare_result(pending_results.pop_front(), got);
      end
    end
    if (in_fire || out_fire)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
